### rtl/ncc_pkg.sv
// Shared types and constants for the NiCd charge controller.
// No dependencies; imported by every module of the block.
package ncc_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int TICK_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int AVG_DEPTH_DEF = 32;

    localparam logic [SAMPLE_W-1:0] HIGH_LIMIT_RST = 10'd818;
    localparam logic [SAMPLE_W-1:0] LOW_LIMIT_RST  = 10'd102;
    localparam logic [SAMPLE_W-1:0] DROP_LIMIT_RST = 10'd61;
    localparam logic [TICK_W-1:0]   TIMEOUT_RST    = 16'd10800;

    typedef enum logic [1:0] {
        MODE_WAIT_BATT   = 2'd0,
        MODE_WAIT_UNPLUG = 2'd1,
        MODE_CHARGING    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_DELTA   = 2'd1,
        CAUSE_TIMEOUT = 2'd2,
        CAUSE_UNPLUG  = 2'd3
    } t_cause;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_LIMIT = 2'd0,
        CFG_LOW_LIMIT  = 2'd1,
        CFG_DROP_LIMIT = 2'd2,
        CFG_TIMEOUT    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] high_limit;
        logic [SAMPLE_W-1:0] low_limit;
        logic [SAMPLE_W-1:0] drop_limit;
        logic [TICK_W-1:0]   timeout;
    } t_cfg;

    typedef struct packed {
        logic   charge_on;
        logic   led_on;
        t_mode  mode;
        t_cause end_cause;
    } t_result;

endpackage

### rtl/ncc_window_mem.sv
// Moving-average sample window: one write port, one registered read port.
// Depends on ncc_pkg for the sample width.
module ncc_window_mem import ncc_pkg::*; #(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(AVG_DEPTH)-1:0] i_rd_addr,
    output logic [SAMPLE_W-1:0]          o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(AVG_DEPTH)-1:0] i_wr_addr,
    input  logic [SAMPLE_W-1:0]          i_wr_data
);

    logic [SAMPLE_W-1:0] r_mem [AVG_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ncc_core.sv
// Charge state machine, running sum, peak tracking and tick timer.
// Depends on ncc_pkg; reads and writes the window held in ncc_window_mem.
module ncc_core import ncc_pkg::*; #(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_commit,
    input  t_op                          i_operation,
    input  logic [SAMPLE_W-1:0]          i_sample,
    input  t_cfg                         i_cfg,
    input  logic [SAMPLE_W-1:0]          i_rd_data,
    output logic                         o_wr_en,
    output logic [$clog2(AVG_DEPTH)-1:0] o_wr_addr,
    output logic [SAMPLE_W-1:0]          o_wr_data,
    output logic [$clog2(AVG_DEPTH)-1:0] o_next_ptr,
    output t_result                      o_result
);

    localparam int PTR_W   = $clog2(AVG_DEPTH);
    localparam int SUM_W   = SAMPLE_W + PTR_W;
    localparam int SHIFT   = SUM_W + PTR_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / depth): exact floor division for any SUM_W-bit sum
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(AVG_DEPTH - 1);

    t_mode                r_mode,  n_mode;
    logic [PTR_W-1:0]     r_ptr,   n_ptr;
    logic [SUM_W-1:0]     r_sum,   n_sum;
    logic [SAMPLE_W-1:0]  r_peak,  n_peak;
    logic [TICK_W-1:0]    r_tick,  n_tick;
    logic                 r_charge, n_charge;
    logic                 r_led,   n_led;
    logic [AVG_DEPTH-1:0] r_valid, n_valid;
    t_cause               w_cause;
    logic                 w_push;

    logic                present;
    logic [SAMPLE_W-1:0] w_old;
    logic [SUM_W-1:0]    w_sum_new;
    logic [PROD_W-1:0]   w_prod;
    logic [SAMPLE_W-1:0] w_avg;
    logic [SAMPLE_W-1:0] w_peak_new;
    logic                w_drop;
    logic [TICK_W-1:0]   w_tick_inc;
    logic [PTR_W-1:0]    w_ptr_inc;

    assign present    = (i_sample > i_cfg.high_limit) || (i_sample < i_cfg.low_limit);
    // entries not written since the charge began read as zero
    assign w_old      = r_valid[r_ptr] ? i_rd_data : '0;
    assign w_sum_new  = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);
    assign w_prod     = PROD_W'(w_sum_new) * PROD_W'(RECIP);
    assign w_avg      = w_prod[SHIFT +: SAMPLE_W];
    assign w_peak_new = (w_avg > r_peak) ? w_avg : r_peak;
    assign w_drop     = (w_peak_new - w_avg) > i_cfg.drop_limit;
    assign w_tick_inc = r_tick + 1'b1;
    assign w_ptr_inc  = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_WAIT_BATT;
            r_ptr    <= '0;
            r_sum    <= '0;
            r_peak   <= '0;
            r_tick   <= '0;
            r_charge <= 1'b0;
            r_led    <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_ptr    <= n_ptr;
            r_sum    <= n_sum;
            r_peak   <= n_peak;
            r_tick   <= n_tick;
            r_charge <= n_charge;
            r_led    <= n_led;
            r_valid  <= n_valid;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_ptr    = r_ptr;
        n_sum    = r_sum;
        n_peak   = r_peak;
        n_tick   = r_tick;
        n_charge = r_charge;
        n_led    = r_led;
        n_valid  = r_valid;
        w_cause  = CAUSE_NONE;
        w_push   = 1'b0;
        if (i_commit) begin
            if (i_operation == OP_SAMPLE) begin
                case (r_mode)
                    MODE_WAIT_UNPLUG: begin
                        if (!present) begin
                            n_mode = MODE_WAIT_BATT;
                        end
                    end
                    MODE_CHARGING: begin
                        if (present) begin
                            w_push         = 1'b1;
                            n_sum          = w_sum_new;
                            n_peak         = w_peak_new;
                            n_ptr          = w_ptr_inc;
                            n_valid[r_ptr] = 1'b1;
                            if (w_drop) begin
                                n_charge = 1'b0;
                                n_mode   = MODE_WAIT_UNPLUG;
                                w_cause  = CAUSE_DELTA;
                            end
                        end else begin
                            n_charge = 1'b0;
                            n_mode   = MODE_WAIT_BATT;
                            w_cause  = CAUSE_UNPLUG;
                        end
                    end
                    default: begin
                        if (present) begin
                            // new charge: window restarts empty
                            n_peak   = '0;
                            n_tick   = '0;
                            n_valid  = '0;
                            n_ptr    = '0;
                            n_sum    = '0;
                            n_charge = 1'b1;
                            n_mode   = MODE_CHARGING;
                        end else begin
                            n_mode = MODE_WAIT_BATT;
                        end
                    end
                endcase
            end else begin
                case (r_mode)
                    MODE_CHARGING: begin
                        n_tick = w_tick_inc;
                        if (w_tick_inc == i_cfg.timeout) begin
                            n_charge = 1'b0;
                            n_mode   = MODE_WAIT_UNPLUG;
                            w_cause  = CAUSE_TIMEOUT;
                            n_led    = ~r_led;
                        end else begin
                            n_led = 1'b1;
                        end
                    end
                    MODE_WAIT_UNPLUG: begin
                        n_led = ~r_led;
                    end
                    default: begin
                        n_mode = MODE_WAIT_BATT;
                        n_led  = 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_wr_en    = w_push;
    assign o_wr_addr  = r_ptr;
    assign o_wr_data  = i_sample;
    assign o_next_ptr = n_ptr;

    assign o_result.charge_on = n_charge;
    assign o_result.led_on    = n_led;
    assign o_result.mode      = n_mode;
    assign o_result.end_cause = w_cause;

endmodule

### rtl/nicd_charge_controller.sv
// NiCd charge controller with negative delta-V termination.
// Flow: an accepted request waits in the s1 register, commits into the output
// register once that is free, and one request per cycle is taken while the output
// is not stalled; the window read is issued at accept, a charging sample's write at commit.
// Reset: synchronous, active low; control and config registers return to defaults, the window
// is empty at once through per-entry valid flags (no clearing pass).
module nicd_charge_controller import ncc_pkg::*; #(
    parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_charge_on,
    output logic                  o_led_on,
    output logic [1:0]            o_mode,
    output logic [1:0]            o_end_cause,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PTR_W = $clog2(AVG_DEPTH);

    t_cfg                r_cfg;
    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_out_valid;
    t_result             r_out;

    logic                w_out_free;
    logic                w_commit;
    logic                w_in_acc;
    t_result             w_result;
    logic [PTR_W-1:0]    w_next_ptr;
    logic [SAMPLE_W-1:0] w_rd_data;
    logic                w_wr_en;
    logic [PTR_W-1:0]    w_wr_addr;
    logic [SAMPLE_W-1:0] w_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_limit <= HIGH_LIMIT_RST;
            r_cfg.low_limit  <= LOW_LIMIT_RST;
            r_cfg.drop_limit <= DROP_LIMIT_RST;
            r_cfg.timeout    <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HIGH_LIMIT: r_cfg.high_limit <= i_cfg_data[SAMPLE_W-1:0];
                CFG_LOW_LIMIT:  r_cfg.low_limit  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_DROP_LIMIT: r_cfg.drop_limit <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TIMEOUT:    r_cfg.timeout    <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = r_s1_valid && w_out_free;
    assign o_in_ready = !r_s1_valid || w_commit;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_commit) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_op     <= t_op'(i_operation);
            r_s1_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    // read address is the pointer as it stands once the item ahead commits
    ncc_window_mem #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_window_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_next_ptr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    ncc_core #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (w_commit),
        .i_operation (r_s1_op),
        .i_sample    (r_s1_sample),
        .i_cfg       (r_cfg),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_next_ptr  (w_next_ptr),
        .o_result    (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_charge_on = r_out.charge_on;
    assign o_led_on    = r_out.led_on;
    assign o_mode      = r_out.mode;
    assign o_end_cause = r_out.end_cause;

endmodule

### dv/nicd_charge_controller_test.sv
`timescale 1ns / 100ps
// Testbench for nicd_charge_controller: ADC samples and ticks go in as requests,
// each status result is checked against a cycle-free model kept in this file.
// Depends on ncc_pkg and the controller RTL.
module nicd_charge_controller_test;
    import ncc_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int WIN_DEPTH        = AVG_DEPTH_DEF;
    localparam int PTR_W            = $clog2(WIN_DEPTH);
    localparam int SUM_W            = SAMPLE_W + PTR_W;
    localparam int SAMPLE_MAX       = (1 << SAMPLE_W) - 1;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int SETTLE_CYCLES    = 4;
    localparam int WRAP_TICKS       = 20;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_operation = OP_SAMPLE;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_charge_on;
    logic                  o_led_on;
    logic [1:0]            o_mode;
    logic [1:0]            o_end_cause;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    nicd_charge_controller u_dut (.*);

    // model state
    t_mode               pred_mode;
    logic [SAMPLE_W-1:0] avg_window [WIN_DEPTH];
    logic [PTR_W-1:0]    win_ptr;
    logic [SUM_W-1:0]    win_sum;
    logic [SAMPLE_W-1:0] peak_avg;
    logic [TICK_W-1:0]   charge_ticks;
    logic                pred_charge;
    logic                pred_led;

    // register shadow
    logic [SAMPLE_W-1:0] cfg_high;
    logic [SAMPLE_W-1:0] cfg_low;
    logic [SAMPLE_W-1:0] cfg_drop;
    logic [TICK_W-1:0]   cfg_timeout;

    t_result     pending_status [$];
    bit          failed         = 1'b0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    endfunction

    function automatic t_result predict_status(input t_op op, input logic [SAMPLE_W-1:0] smp);
        t_result             res;
        t_cause              cause;
        logic                present;
        logic [SAMPLE_W-1:0] cur_avg;
        int                  i;
        cause   = CAUSE_NONE;
        present = (smp > cfg_high) || (smp < cfg_low);
        if (op == OP_SAMPLE) begin
            if (present) begin
                if (pred_mode == MODE_WAIT_BATT) begin
                    // fresh charge; the starting sample stays out of the window
                    for (i = 0; i < WIN_DEPTH; i++) avg_window[i] = '0;
                    win_ptr      = '0;
                    win_sum      = '0;
                    peak_avg     = '0;
                    charge_ticks = '0;
                    pred_charge  = 1'b1;
                    pred_mode    = MODE_CHARGING;
                end else if (pred_mode == MODE_CHARGING) begin
                    win_sum             = win_sum - avg_window[win_ptr] + smp;
                    avg_window[win_ptr] = smp;
                    win_ptr             = win_ptr + 1'b1;
                    cur_avg             = SAMPLE_W'(win_sum / WIN_DEPTH);
                    if (cur_avg > peak_avg) peak_avg = cur_avg;
                    if (peak_avg - cur_avg > cfg_drop) begin
                        pred_charge = 1'b0;
                        pred_mode   = MODE_WAIT_UNPLUG;
                        cause       = CAUSE_DELTA;
                    end
                end
            end else begin
                if (pred_mode == MODE_CHARGING) begin
                    pred_charge = 1'b0;
                    cause       = CAUSE_UNPLUG;
                end
                pred_mode = MODE_WAIT_BATT;
            end
        end else begin
            if (pred_mode == MODE_CHARGING) begin
                charge_ticks = charge_ticks + 1'b1;
                if (charge_ticks == cfg_timeout) begin
                    pred_charge = 1'b0;
                    pred_mode   = MODE_WAIT_UNPLUG;
                    cause       = CAUSE_TIMEOUT;
                end
            end
            case (pred_mode)
                MODE_WAIT_BATT:   pred_led = 1'b0;
                MODE_WAIT_UNPLUG: pred_led = ~pred_led;
                default:          pred_led = 1'b1;
            endcase
        end
        res.charge_on = pred_charge;
        res.led_on    = pred_led;
        res.mode      = pred_mode;
        res.end_cause = cause;
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected status, expected none, got charge=%0d led=%0d mode=%0d cause=%0d",
                         $time, o_charge_on, o_led_on, o_mode, o_end_cause);
                failed = 1'b1;
            end else begin
                want = pending_status.pop_front();
                check_field("charge_on", want.charge_on, o_charge_on);
                check_field("led_on", want.led_on, o_led_on);
                check_field("mode", want.mode, o_mode);
                check_field("end_cause", want.end_cause, o_end_cause);
            end
        end
    end

    task automatic send_request(input t_op op, input logic [SAMPLE_W-1:0] smp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_operation <= 1'($urandom_range(0, 1));
            i_sample    <= rand_sample();
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_sample    <= smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_status.push_back(predict_status(op, smp));
        items_sent++;
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_HIGH_LIMIT: cfg_high    = val[SAMPLE_W-1:0];
            CFG_LOW_LIMIT:  cfg_low     = val[SAMPLE_W-1:0];
            CFG_DROP_LIMIT: cfg_drop    = val[SAMPLE_W-1:0];
            default:        cfg_timeout = val[TICK_W-1:0];
        endcase
    endtask

    // 10-bit registers get junk in the unused upper data bits
    task automatic set_config(input int hi, input int lo, input int drop, input int tmo);
        wait_until_idle();
        write_register(CFG_HIGH_LIMIT,
                       CFG_DATA_W'((hi & SAMPLE_MAX) | ($urandom & ~SAMPLE_MAX)));
        write_register(CFG_LOW_LIMIT,
                       CFG_DATA_W'((lo & SAMPLE_MAX) | ($urandom & ~SAMPLE_MAX)));
        write_register(CFG_DROP_LIMIT,
                       CFG_DATA_W'((drop & SAMPLE_MAX) | ($urandom & ~SAMPLE_MAX)));
        write_register(CFG_TIMEOUT, CFG_DATA_W'(tmo));
    endtask

    // Present sample from the band above the high limit or below the low one.
    // Rising picks push the average up, falling picks pull it down.
    function automatic logic [SAMPLE_W-1:0] pick_present(input bit rising);
        int up_lo;
        int dn_hi;
        up_lo = int'(cfg_high) + 1;
        dn_hi = int'(cfg_low) - 1;
        if (up_lo <= SAMPLE_MAX && (rising || dn_hi < 0))
            return rising ? SAMPLE_W'($urandom_range(up_lo, SAMPLE_MAX))
                          : SAMPLE_W'($urandom_range(up_lo, (up_lo + SAMPLE_MAX) / 2));
        if (dn_hi >= 0)
            return rising ? SAMPLE_W'($urandom_range(dn_hi / 2, dn_hi))
                          : SAMPLE_W'($urandom_range(0, dn_hi / 2));
        return rand_sample();
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_absent();
        if (cfg_low <= cfg_high)
            return SAMPLE_W'($urandom_range(int'(cfg_low), int'(cfg_high)));
        return rand_sample();
    endfunction

    // One battery session: noise, plug in, ramp up then sag, then unplug.
    task automatic run_charge_cycle();
        int len;
        int rise_len;
        int r;
        int i;
        len      = $urandom_range(10, 80);
        rise_len = $urandom_range(4, 45);
        repeat ($urandom_range(0, 3))
            send_request(t_op'($urandom_range(0, 1)), rand_sample());
        send_request(OP_SAMPLE, pick_present(1'b1));
        for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_request(OP_TICK, rand_sample());
            else if (r < 17)
                send_request(OP_SAMPLE, pick_absent());
            else if (r < 19)
                send_request(OP_SAMPLE, rand_sample());
            else
                send_request(OP_SAMPLE, pick_present(i < rise_len));
        end
        // if the charge ended, LED blinks and present samples are ignored
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0)
                send_request(OP_SAMPLE, pick_present(1'b1));
            else
                send_request(OP_TICK, rand_sample());
        end
        send_request(OP_SAMPLE, pick_absent());
    endtask

    task automatic test_presence_and_unplug();
        send_request(OP_TICK, 10'd0);
        send_request(OP_SAMPLE, 10'd500);
        send_request(OP_SAMPLE, HIGH_LIMIT_RST);       // limits themselves are absent
        send_request(OP_SAMPLE, LOW_LIMIT_RST);
        send_request(OP_SAMPLE, HIGH_LIMIT_RST + 1'b1);
        send_request(OP_TICK, 10'h3FF);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'd500);              // pulled mid-charge
        send_request(OP_TICK, 10'd0);
        send_request(OP_SAMPLE, LOW_LIMIT_RST - 1'b1);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'd600);
    endtask

    task automatic test_delta_drop();
        set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, 0, TIMEOUT_RST);
        send_request(OP_SAMPLE, 10'h3FF);
        repeat (WIN_DEPTH) send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'h3FE);              // smallest possible sag
        send_request(OP_TICK, 10'd0);
        send_request(OP_TICK, 10'd0);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'd500);
        set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, SAMPLE_MAX, TIMEOUT_RST);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'd500);
    endtask

    task automatic test_timeout();
        set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, DROP_LIMIT_RST, 1);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_TICK, 10'd0);
        send_request(OP_TICK, 10'd0);
        send_request(OP_TICK, 10'd0);
        send_request(OP_SAMPLE, 10'd500);
        send_request(OP_TICK, 10'd0);
        set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, DROP_LIMIT_RST, 2);
        send_request(OP_TICK, 10'd0);                  // no battery: not counted
        send_request(OP_TICK, 10'd0);
        send_request(OP_SAMPLE, 10'd5);
        send_request(OP_TICK, 10'd0);
        send_request(OP_TICK, 10'd0);
        send_request(OP_SAMPLE, 10'd500);
    endtask

    task automatic test_limit_extremes();
        set_config(SAMPLE_MAX, 0, DROP_LIMIT_RST, TIMEOUT_RST);   // nothing is present
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_TICK, 10'd0);
        set_config(0, SAMPLE_MAX, DROP_LIMIT_RST, TIMEOUT_RST);   // everything is present
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'd512);
        send_request(OP_TICK, 10'd0);
        set_config(0, 0, DROP_LIMIT_RST, TIMEOUT_RST);
        send_request(OP_SAMPLE, 10'd0);
        send_request(OP_SAMPLE, 10'd1);
        send_request(OP_SAMPLE, 10'd0);
        set_config(SAMPLE_MAX, SAMPLE_MAX, DROP_LIMIT_RST, TIMEOUT_RST);
        send_request(OP_SAMPLE, 10'h3FF);
        send_request(OP_SAMPLE, 10'h3FE);
        send_request(OP_SAMPLE, 10'h3FF);
    endtask

    // Largest timeout, then zero, which only fires once the 16-bit count wraps;
    // a short charge must run past either one without ending.
    task automatic test_tick_count_wrap();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, DROP_LIMIT_RST, 16'hFFFF);
        send_request(OP_SAMPLE, 10'h3FF);
        repeat (WRAP_TICKS) send_request(OP_TICK, rand_sample());
        send_request(OP_SAMPLE, 10'd500);
        set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, DROP_LIMIT_RST, 0);
        send_request(OP_SAMPLE, 10'h3FF);
        repeat (WRAP_TICKS) send_request(OP_TICK, rand_sample());
        send_request(OP_SAMPLE, 10'd500);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        int seg;
        int start_cnt;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (seg = 0; seg < 3; seg++) begin
            case (seg)
                0: set_config(HIGH_LIMIT_RST, LOW_LIMIT_RST, DROP_LIMIT_RST,
                              $urandom_range(10, 40));
                1: set_config($urandom_range(600, 1000), $urandom_range(20, 400),
                              $urandom_range(0, 150), $urandom_range(3, 60));
                default: set_config($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                                    $urandom_range(0, SAMPLE_MAX), $urandom_range(1, 200));
            endcase
            start_cnt = items_sent;
            while (items_sent - start_cnt < RANDOM_PER_PHASE / 3) begin
                run_charge_cycle();
                // hold off until every status is back
                if ($urandom_range(0, 19) == 0) wait_until_idle();
            end
        end
    endtask

    initial begin
        pred_mode    = MODE_WAIT_BATT;
        win_ptr      = '0;
        win_sum      = '0;
        peak_avg     = '0;
        charge_ticks = '0;
        pred_charge  = 1'b0;
        pred_led     = 1'b0;
        for (int i = 0; i < WIN_DEPTH; i++) avg_window[i] = '0;
        cfg_high     = HIGH_LIMIT_RST;
        cfg_low      = LOW_LIMIT_RST;
        cfg_drop     = DROP_LIMIT_RST;
        cfg_timeout  = TIMEOUT_RST;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_presence_and_unplug();
        test_delta_drop();
        test_timeout();
        test_limit_extremes();
        test_tick_count_wrap();
        test_random_traffic(0, 0);
        test_random_traffic(59, 0);
        test_random_traffic(0, 59);
        test_random_traffic(6, 6);

        wait_until_idle();
        repeat (8) @(posedge i_clk);
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/ncc_pkg.sv
rtl/ncc_window_mem.sv
rtl/ncc_core.sv
rtl/nicd_charge_controller.sv
dv/nicd_charge_controller_test.sv
